@@ rtl/ibu_pkg.sv @@
// Shared types, constants and colour blend functions for the bilinear image upscaler.
package ibu_pkg;

    // Field widths fixed by the interface.
    localparam int SIZE_W   = 14;
    localparam int DST_W    = 13;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int FRAC_W   = 8;
    localparam int HALF_SH  = 15;
    localparam int CELL_SH  = 16;
    localparam int CIDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_OUT_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_OUT_HEIGHT = 2'd1;

    // Request modes.
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_REQ  = 1'b1
    } mode_t;

    // Side information that travels with a request through the divider pipeline.
    typedef struct packed {
        logic              req;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  pixel;
        logic              nearest;
    } load_tag_t;

    // Control that travels alongside the memory read and the blend stages.
    typedef struct packed {
        logic              valid;
        logic              req;
        logic              left_odd;
        logic              right_same;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } ctl_t;

    // Blend of one 8-bit channel with weights 256-f and f.
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [FRAC_W-1:0] f);
        logic [CH_W+FRAC_W:0] s;
        s = (CH_W+FRAC_W+1)'(a) * (CH_W+FRAC_W+1)'(9'd256 - {1'b0, f})
          + (CH_W+FRAC_W+1)'(b) * (CH_W+FRAC_W+1)'(f);
        return s[CH_W+FRAC_W-1:FRAC_W];
    endfunction

    // Blend of a whole RGB pixel, channel by channel.
    function automatic logic [PIX_W-1:0] blend_pix(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [FRAC_W-1:0] f);
        logic [PIX_W-1:0] r;
        r[23:16] = blend_ch(a[23:16], b[23:16], f);
        r[15:8]  = blend_ch(a[15:8], b[15:8], f);
        r[7:0]   = blend_ch(a[7:0], b[7:0], f);
        return r;
    endfunction

endpackage

@@ rtl/ibu_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module ibu_div_pipe
    import ibu_pkg::*;
#(
    parameter int NUM_W = 38,
    parameter int DEN_W = 14,
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [TAG_W-1:0] in_tag,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quot,
    output logic [TAG_W-1:0] out_tag
);

    localparam int ACC_W = DEN_W + NUM_W;

    logic [ACC_W-1:0] acc_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];
    logic [NUM_W-1:0] valid_reg;

    // One restoring step: shift in the next numerator bit and try to subtract.
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input logic [DEN_W-1:0] d);
        logic [DEN_W:0] hi;
        logic [DEN_W:0] diff;
        logic           q;
        hi = acc[ACC_W-1 -: DEN_W+1];
        if (hi >= {1'b0, d})
        begin
            diff = hi - {1'b0, d};
            q    = 1'b1;
        end
        else
        begin
            diff = hi;
            q    = 1'b0;
        end
        return {diff[DEN_W-1:0], acc[NUM_W-2:0], q};
    endfunction

    // Valid bits shift along with the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
        end
    end

    // Each stage resolves one quotient bit, most significant first.
    always_ff @(posedge clk)
    begin
        acc_reg[0] <= div_step({{DEN_W{1'b0}}, in_num}, den);
        tag_reg[0] <= in_tag;
        for (int i = 1; i < NUM_W; i++)
        begin
            acc_reg[i] <= div_step(acc_reg[i-1], den);
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quot  = acc_reg[NUM_W-1][NUM_W-1:0];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

@@ rtl/ibu_frame_mem.sv @@
// Source frame store split into even-column and odd-column banks, each with two read ports.
module ibu_frame_mem
    import ibu_pkg::*;
#(
    parameter int DEPTH = 38400,
    parameter int AW    = 16
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic             wr_odd,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_even_a,
    input  logic [AW-1:0]    rd_even_b,
    input  logic [AW-1:0]    rd_odd_a,
    input  logic [AW-1:0]    rd_odd_b,
    output logic [PIX_W-1:0] even_a,
    output logic [PIX_W-1:0] even_b,
    output logic [PIX_W-1:0] odd_a,
    output logic [PIX_W-1:0] odd_b
);

    logic [PIX_W-1:0] even_mem [DEPTH];
    logic [PIX_W-1:0] odd_mem  [DEPTH];
    logic [PIX_W-1:0] even_a_reg;
    logic [PIX_W-1:0] even_b_reg;
    logic [PIX_W-1:0] odd_a_reg;
    logic [PIX_W-1:0] odd_b_reg;

    // Load writes go to the bank that holds the column's parity.
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_odd)
        begin
            even_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_odd)
        begin
            odd_mem[wr_addr] <= wr_data;
        end
    end

    // Registered reads of the upper and lower rows from both banks.
    always_ff @(posedge clk)
    begin
        even_a_reg <= even_mem[rd_even_a];
        even_b_reg <= even_mem[rd_even_b];
        odd_a_reg  <= odd_mem[rd_odd_a];
        odd_b_reg  <= odd_mem[rd_odd_b];
    end

    assign even_a = even_a_reg;
    assign even_b = even_b_reg;
    assign odd_a  = odd_a_reg;
    assign odd_b  = odd_b_reg;

endmodule

@@ rtl/ibu_blend.sv @@
// Two-stage colour blend: vertical blend of both columns, then horizontal blend.
module ibu_blend
    import ibu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  logic [PIX_W-1:0] even_a,
    input  logic [PIX_W-1:0] even_b,
    input  logic [PIX_W-1:0] odd_a,
    input  logic [PIX_W-1:0] odd_b,
    output logic             done,
    output logic [PIX_W-1:0] rgb_out,
    output logic             retire
);

    logic [PIX_W-1:0]  left_top;
    logic [PIX_W-1:0]  left_bot;
    logic [PIX_W-1:0]  right_top;
    logic [PIX_W-1:0]  right_bot;
    logic [PIX_W-1:0]  left_reg;
    logic [PIX_W-1:0]  right_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic              valid_reg;
    logic              req_reg;
    logic [PIX_W-1:0]  rgb_reg;
    logic              done_reg;
    logic              retire_reg;

    // Pick the left and right columns from the two banks.
    always_comb
    begin
        left_top = ctl.left_odd ? odd_a : even_a;
        left_bot = ctl.left_odd ? odd_b : even_b;
        if (ctl.right_same)
        begin
            right_top = left_top;
            right_bot = left_bot;
        end
        else
        begin
            right_top = ctl.left_odd ? even_a : odd_a;
            right_bot = ctl.left_odd ? even_b : odd_b;
        end
    end

    // Vertical blend of both columns, then horizontal blend of the two results.
    always_ff @(posedge clk)
    begin
        left_reg  <= blend_pix(left_top, left_bot, ctl.fy);
        right_reg <= blend_pix(right_top, right_bot, ctl.fy);
        fx_reg    <= ctl.fx;
        rgb_reg   <= blend_pix(left_reg, right_reg, fx_reg);
    end

    // Control for the two blend stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            req_reg    <= 1'b0;
            done_reg   <= 1'b0;
            retire_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= ctl.valid;
            req_reg    <= ctl.req;
            done_reg   <= valid_reg && req_reg;
            retire_reg <= valid_reg;
        end
    end

    assign done    = done_reg;
    assign rgb_out = rgb_reg;
    assign retire  = retire_reg;

endmodule

@@ rtl/bilinear_image_upscaler.sv @@
// Top level of the bilinear image upscaler: request intake, coordinate mapping, addressing.
//
// The block takes one request per clock and never raises busy. A load request writes one
// source pixel if it lies inside the frame; a colour request returns its pixel on rgb_out
// with done high for one cycle, in request order. The path runs through an intake register,
// the restoring dividers, which resolve one quotient bit per pipeline stage, then mapping,
// addressing, the frame store read and two blend stages. The receiver cannot stall the
// result. The size registers are written through the configuration channel, whose ready is
// high only while no request is in flight and no new one is being presented. The frame store
// has no reset; reading a pixel never loaded is undefined.
module bilinear_image_upscaler
    import ibu_pkg::*;
#(
    parameter int SRC_W       = 320,
    parameter int SRC_H       = 240,
    parameter int TABLE_LIMIT = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [COL_W-1:0]  src_col,
    input  logic [ROW_W-1:0]  src_row,
    input  logic [PIX_W-1:0]  src_pixel,
    input  logic [DST_W-1:0]  dst_col,
    input  logic [DST_W-1:0]  dst_row,
    output logic              done,
    output logic [PIX_W-1:0]  rgb_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int NUM_X  = HALF_SH + SIZE_W + $clog2(SRC_W + 1);
    localparam int NUM_Y  = HALF_SH + SIZE_W + $clog2(SRC_H + 1);
    localparam int NUM_W  = (NUM_X > NUM_Y) ? NUM_X : NUM_Y;
    localparam int LAT    = NUM_W + 6;
    localparam int CNT_W  = $clog2(LAT + 2);
    localparam int XW     = $clog2(SRC_W);
    localparam int YW     = $clog2(SRC_H);
    localparam int EVEN_W = (SRC_W + 1) / 2;
    localparam int DEPTH  = EVEN_W * SRC_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int TAG_W  = $bits(load_tag_t);
    localparam logic [NUM_W-1:0] HALF_Q = NUM_W'(1) << HALF_SH;
    localparam logic [NUM_W-1:0] MAX_X  = NUM_W'(SRC_W - 1) << CELL_SH;
    localparam logic [NUM_W-1:0] MAX_Y  = NUM_W'(SRC_H - 1) << CELL_SH;

    logic              accept;
    logic [SIZE_W-1:0] w_reg;
    logic [SIZE_W-1:0] h_reg;
    logic [CNT_W-1:0]  inflight_reg;
    logic [CNT_W-1:0]  inflight_next;
    logic              retire;

    logic [DST_W-1:0]  x_sat;
    logic [DST_W-1:0]  y_sat;
    logic              nearest;
    logic [NUM_W-1:0]  num_x_next;
    logic [NUM_W-1:0]  num_y_next;
    logic [NUM_W-1:0]  num_x_reg;
    logic [NUM_W-1:0]  num_y_reg;
    load_tag_t         tag_reg;
    logic              v0_reg;

    logic              qx_valid;
    logic              qy_valid;
    logic [NUM_W-1:0]  qx;
    logic [NUM_W-1:0]  qy;
    logic [TAG_W-1:0]  qx_tag_bits;
    load_tag_t         qx_tag;
    logic              qy_nearest;

    logic [NUM_W-1:0]  fxp;
    logic [NUM_W-1:0]  fyp;
    logic [XW-1:0]     x0_next;
    logic [YW-1:0]     y0_next;
    logic [FRAC_W-1:0] fx_next;
    logic [FRAC_W-1:0] fy_next;

    logic              v1_reg;
    load_tag_t         tag1_reg;
    logic [XW-1:0]     x0_reg;
    logic [YW-1:0]     y0_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic [FRAC_W-1:0] fy_reg;

    logic [XW-1:0]     x1;
    logic [YW-1:0]     y1;
    logic [XW-1:0]     ecol;
    logic [XW-1:0]     ocol;
    logic [AW-1:0]     base0;
    logic [AW-1:0]     base1;
    logic              wr_ok;
    ctl_t              ctl_next;

    ctl_t              ctl_p2_reg;
    ctl_t              ctl_p3_reg;
    logic [AW-1:0]     rd_even_a_reg;
    logic [AW-1:0]     rd_even_b_reg;
    logic [AW-1:0]     rd_odd_a_reg;
    logic [AW-1:0]     rd_odd_b_reg;
    logic              wr_en_reg;
    logic              wr_odd_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [PIX_W-1:0]  wr_data_reg;

    logic [PIX_W-1:0]  even_a;
    logic [PIX_W-1:0]  even_b;
    logic [PIX_W-1:0]  odd_a;
    logic [PIX_W-1:0]  odd_b;

    // Requests are never held off.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = (inflight_reg == '0) && !start;

    // Size registers; a written zero counts as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= SIZE_W'(320);
            h_reg <= SIZE_W'(240);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OUT_WIDTH:  w_reg <= (cfg_data == '0) ? SIZE_W'(1) : cfg_data;
                CFG_OUT_HEIGHT: h_reg <= (cfg_data == '0) ? SIZE_W'(1) : cfg_data;
                default:        ;
            endcase
        end
    end

    // Count of requests between intake and the last blend stage.
    assign inflight_next = inflight_reg + CNT_W'(accept) - CNT_W'(retire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Saturate the coordinates and form the division numerators.
    always_comb
    begin
        x_sat   = ({1'b0, dst_col} >= w_reg) ? DST_W'(w_reg - SIZE_W'(1)) : dst_col;
        y_sat   = ({1'b0, dst_row} >= h_reg) ? DST_W'(h_reg - SIZE_W'(1)) : dst_row;
        nearest = (w_reg > SIZE_W'(TABLE_LIMIT)) || (h_reg > SIZE_W'(TABLE_LIMIT));
        if (nearest)
        begin
            num_x_next = NUM_W'(x_sat) * NUM_W'(SRC_W);
            num_y_next = NUM_W'(y_sat) * NUM_W'(SRC_H);
        end
        else
        begin
            num_x_next = (NUM_W'({x_sat, 1'b1}) * NUM_W'(SRC_W)) << HALF_SH;
            num_y_next = (NUM_W'({y_sat, 1'b1}) * NUM_W'(SRC_H)) << HALF_SH;
        end
    end

    always_ff @(posedge clk)
    begin
        num_x_reg       <= num_x_next;
        num_y_reg       <= num_y_next;
        tag_reg.req     <= (mode == MODE_REQ);
        tag_reg.col     <= src_col;
        tag_reg.row     <= src_row;
        tag_reg.pixel   <= src_pixel;
        tag_reg.nearest <= nearest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    // Column and row dividers run in lockstep.
    ibu_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (SIZE_W),
        .TAG_W (TAG_W)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_num    (num_x_reg),
        .in_tag    (tag_reg),
        .den       (w_reg),
        .out_valid (qx_valid),
        .out_quot  (qx),
        .out_tag   (qx_tag_bits)
    );

    ibu_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (SIZE_W),
        .TAG_W (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_num    (num_y_reg),
        .in_tag    (tag_reg.nearest),
        .den       (h_reg),
        .out_valid (qy_valid),
        .out_quot  (qy),
        .out_tag   (qy_nearest)
    );

    assign qx_tag = load_tag_t'(qx_tag_bits);

    // Map quotients to a source cell and fraction, clamped to the frame.
    always_comb
    begin
        fxp = (qx < HALF_Q) ? '0 : qx - HALF_Q;
        if (fxp > MAX_X)
        begin
            fxp = MAX_X;
        end
        fyp = (qy < HALF_Q) ? '0 : qy - HALF_Q;
        if (fyp > MAX_Y)
        begin
            fyp = MAX_Y;
        end
        if (qx_tag.nearest)
        begin
            x0_next = qx[XW-1:0];
            fx_next = '0;
        end
        else
        begin
            x0_next = fxp[CELL_SH +: XW];
            fx_next = fxp[CELL_SH-1 -: FRAC_W];
        end
        if (qy_nearest)
        begin
            y0_next = qy[YW-1:0];
            fy_next = '0;
        end
        else
        begin
            y0_next = fyp[CELL_SH +: YW];
            fy_next = fyp[CELL_SH-1 -: FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= qx_tag;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= qx_valid;
        end
    end

    // Neighbour cells and bank addresses; the last column and row repeat at the edge, and
    // nearest sampling reads only the cell itself.
    always_comb
    begin
        x1    = (!tag1_reg.nearest && (x0_reg < XW'(SRC_W - 1))) ? x0_reg + XW'(1) : x0_reg;
        y1    = (!tag1_reg.nearest && (y0_reg < YW'(SRC_H - 1))) ? y0_reg + YW'(1) : y0_reg;
        ocol  = x0_reg >> 1;
        ecol  = x0_reg[0] ? (x1 >> 1) : (x0_reg >> 1);
        base0 = AW'(y0_reg) * AW'(EVEN_W);
        base1 = AW'(y1) * AW'(EVEN_W);
        wr_ok = (int'(tag1_reg.col) < SRC_W) && (int'(tag1_reg.row) < SRC_H);

        ctl_next.valid      = v1_reg;
        ctl_next.req        = tag1_reg.req;
        ctl_next.left_odd   = x0_reg[0];
        ctl_next.right_same = (x1 == x0_reg);
        ctl_next.fx         = fx_reg;
        ctl_next.fy         = fy_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_even_a_reg <= base0 + AW'(ecol);
        rd_even_b_reg <= base1 + AW'(ecol);
        rd_odd_a_reg  <= base0 + AW'(ocol);
        rd_odd_b_reg  <= base1 + AW'(ocol);
        wr_odd_reg    <= tag1_reg.col[0];
        wr_addr_reg   <= AW'(tag1_reg.row) * AW'(EVEN_W) + AW'(tag1_reg.col >> 1);
        wr_data_reg   <= tag1_reg.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_p2_reg <= '0;
            ctl_p3_reg <= '0;
            wr_en_reg  <= 1'b0;
        end
        else
        begin
            ctl_p2_reg <= ctl_next;
            ctl_p3_reg <= ctl_p2_reg;
            wr_en_reg  <= v1_reg && !tag1_reg.req && wr_ok;
        end
    end

    // Frame store: loads write and colour requests read at the same pipeline point.
    ibu_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en_reg),
        .wr_odd    (wr_odd_reg),
        .wr_addr   (wr_addr_reg),
        .wr_data   (wr_data_reg),
        .rd_even_a (rd_even_a_reg),
        .rd_even_b (rd_even_b_reg),
        .rd_odd_a  (rd_odd_a_reg),
        .rd_odd_b  (rd_odd_b_reg),
        .even_a    (even_a),
        .even_b    (even_b),
        .odd_a     (odd_a),
        .odd_b     (odd_b)
    );

    ibu_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_p3_reg),
        .even_a  (even_a),
        .even_b  (even_b),
        .odd_a   (odd_a),
        .odd_b   (odd_b),
        .done    (done),
        .rgb_out (rgb_out),
        .retire  (retire)
    );

    // A colour request produces its result after the fixed pipeline latency.
    a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_REQ) |-> ##LAT done)
        else $error("colour request did not complete after the pipeline latency");

    // A load request never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_LOAD) |-> ##LAT !done)
        else $error("load request produced a result");

    // Both dividers carry the same requests.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        qx_valid == qy_valid)
        else $error("column and row dividers out of step");

    // A result always belongs to a request that is still counted in flight.
    a_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> inflight_reg != '0)
        else $error("result with no request in flight");

    // Sizes never become zero.
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> (w_reg != '0) && (h_reg != '0))
        else $error("output size register holds zero");

endmodule
